// File: rtl/core/barometer_integer_compensation_top_assert.svh
// assertion macros for the barometer compensation block
// no dependencies; included by the top level
`ifndef BAROMETER_INTEGER_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETER_INTEGER_COMPENSATION_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define BIC_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define BIC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bic_pkg.sv
// shared types and constants of the barometer compensation block
// no dependencies; used by bic_div and the top level
package bic_pkg;

	localparam int NUM_W      = 64;
	localparam int DEN_W      = 31;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;

	localparam int TC_W       = 16;
	localparam int TF_W       = 32;
	localparam int PR_W       = 32;
	localparam int RAW_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic signed [32:0] T_OFFSET    = 33'sd128000;
	localparam logic [20:0]        P_BASE      = 21'd1048576;
	localparam logic [11:0]        PRESS_SCALE = 12'd3125;
	localparam logic [31:0]        TC_ROUND    = 32'd128;
	localparam logic [63:0]        VB_BIAS     = 64'h0000_8000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP  = 2'd0,
		REG_PLOW  = 2'd1,
		REG_PHIGH = 2'd2,
		REG_P9    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             dz;
		logic [TC_W-1:0]  tc;
		logic [TF_W-1:0]  tf;
	} div_in_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] quot;
		logic             neg;
		logic             dz;
		logic [TC_W-1:0]  tc;
		logic [TF_W-1:0]  tf;
	} div_out_t;

	typedef struct packed {
		logic [TC_W-1:0] tc;
		logic [TF_W-1:0] tf;
		logic [PR_W-1:0] press;
		logic            dz;
	} res_t;

endpackage

// File: rtl/core/bic_div.sv
// pipelined unsigned divider, two quotient bits per stage
// depends on bic_pkg
module bic_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  bic_pkg::div_in_t  din,
	output bic_pkg::div_out_t dout
);
	import bic_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] word;
	} div_state_t;

	typedef struct packed {
		div_state_t       st;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             dz;
		logic [TC_W-1:0]  tc;
		logic [TF_W-1:0]  tf;
	} div_stage_t;

	// restoring step: numerator bits leave at the top, quotient bits enter at the bottom
	function automatic div_state_t div_step(div_state_t st, logic [DEN_W-1:0] d);
		logic [DEN_W:0] r2;
		logic           ge;
		div_state_t     nx;
		r2 = {st.rem, st.word[NUM_W-1]};
		ge = (r2 >= {1'b0, d});
		nx.rem = ge ? DEN_W'(r2 - {1'b0, d}) : r2[DEN_W-1:0];
		nx.word = {st.word[NUM_W-2:0], ge};
		return nx;
	endfunction

	logic       valid_sn [DIV_STAGES];
	div_stage_t data_sn  [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		div_stage_t prev;
		div_stage_t cur;
		logic       prev_valid;

		if (g == 0) begin : g_first
			assign prev = {{DEN_W{1'b0}}, din.num, din.den, din.neg, din.dz, din.tc, din.tf};
			assign prev_valid = din.valid;
		end else begin : g_next
			assign prev = data_sn[g-1];
			assign prev_valid = valid_sn[g-1];
		end

		always_comb begin
			cur = prev;
			for (int k = 0; k < DIV_STEPS; k++) begin
				cur.st = div_step(cur.st, cur.den);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[g] <= 1'b0;
			end else if (en) begin
				valid_sn[g] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				data_sn[g] <= cur;
			end
		end
	end

	assign dout.valid = valid_sn[DIV_STAGES-1];
	assign dout.quot  = data_sn[DIV_STAGES-1].st.word;
	assign dout.neg   = data_sn[DIV_STAGES-1].neg;
	assign dout.dz    = data_sn[DIV_STAGES-1].dz;
	assign dout.tc    = data_sn[DIV_STAGES-1].tc;
	assign dout.tf    = data_sn[DIV_STAGES-1].tf;

endmodule

// File: rtl/core/barometer_integer_compensation_top.sv
// channel  | dir | handshake           | payload
// in       | in  | in_valid / in_stall  | raw_temperature, raw_pressure
// out      | out | out_valid / out_stall| temperature_centi, fine_temperature,
//          |     |                      | pressure_q24_8, divide_by_zero
// cfg      | in  | cfg_write            | cfg_index, cfg_data
// one pair per cycle while in_stall is low
// the pipeline holds the 32-stage divider array, two quotient bits per stage
// reset clears coefficients, valid bits and the output buffer count
// a two-entry output buffer absorbs out_stall; in_stall rises only when it is full,
// and then the whole pipeline holds
// depends on bic_pkg, bic_div and the assertion macro header
`include "barometer_integer_compensation_top_assert.svh"

module barometer_integer_compensation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bic_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bic_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bic_pkg::RAW_W-1:0]           raw_temperature,
	input  logic [bic_pkg::RAW_W-1:0]           raw_pressure,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bic_pkg::TC_W-1:0]     temperature_centi,
	output logic signed [bic_pkg::TF_W-1:0]     fine_temperature,
	output logic [bic_pkg::PR_W-1:0]            pressure_q24_8,
	output logic                                divide_by_zero
);
	import bic_pkg::*;

	// coefficient registers
	logic [47:0] temp_q;
	logic [63:0] plow_q;
	logic [63:0] phigh_q;
	logic [15:0] p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			p9_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP:  temp_q  <= cfg_data[47:0];
				REG_PLOW:  plow_q  <= cfg_data;
				REG_PHIGH: phigh_q <= cfg_data;
				REG_P9:    p9_q    <= cfg_data[15:0];
				default:   ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_q[15:0];
	assign t2 = $signed(temp_q[31:16]);
	assign t3 = $signed(temp_q[47:32]);
	assign p1 = plow_q[15:0];
	assign p2 = $signed(plow_q[31:16]);
	assign p3 = $signed(plow_q[47:32]);
	assign p4 = $signed(plow_q[63:48]);
	assign p5 = $signed(phigh_q[15:0]);
	assign p6 = $signed(phigh_q[31:16]);
	assign p7 = $signed(phigh_q[47:32]);
	assign p8 = $signed(phigh_q[63:48]);
	assign p9 = $signed(p9_q);

	// output buffer state and pipeline enable
	logic [1:0] cnt_q;
	logic       en;
	assign en = (cnt_q != 2'd2);
	assign in_stall = !en;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s13, v_s14, v_s15, v_s16, v_s17;
	div_out_t dout;

	// stage 1: temperature differences and first products
	logic signed [18:0] a_c;
	logic signed [17:0] d_c;
	logic signed [34:0] at_f;
	logic signed [35:0] dd_f;
	assign a_c  = $signed({2'b0, raw_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
	assign d_c  = $signed({2'b0, raw_temperature[19:4]}) - $signed({2'b0, t1});
	assign at_f = a_c * t2;
	assign dd_f = d_c * d_c;

	logic [31:0] at_s1, dd_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;

	// stage 2
	logic signed [31:0] x_c;
	logic signed [47:0] xt3_f;
	assign x_c   = $signed(dd_s1) >>> 12;
	assign xt3_f = x_c * t3;
	logic [31:0] tv1_s2, xt3_s2;

	// stage 3: fine temperature
	logic [31:0] tf_s3;

	// stage 4: temperature in centidegrees and pressure offset
	logic [31:0]        tc_raw;
	logic signed [31:0] tc32;
	logic [15:0]        tc_sat;
	assign tc_raw = (tf_s3 << 2) + tf_s3 + TC_ROUND;
	assign tc32   = $signed(tc_raw) >>> 8;
	always_comb begin
		if (tc32 > 32'sd32767) begin
			tc_sat = 16'h7fff;
		end else if (tc32 < -32'sd32768) begin
			tc_sat = 16'h8000;
		end else begin
			tc_sat = tc32[15:0];
		end
	end
	logic signed [32:0] v1_s4;
	logic [15:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11;
	logic [31:0] tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9, tf_s10, tf_s11;

	// stage 5: square and linear terms of the offset
	logic signed [65:0] sq_f;
	logic signed [48:0] v1p5_f, v1p2_f;
	assign sq_f   = v1_s4 * v1_s4;
	assign v1p5_f = v1_s4 * p5;
	assign v1p2_f = v1_s4 * p2;
	logic [63:0] sq_s5;
	logic [48:0] v1p5_s5, v1p2_s5, v1p5_s6, v1p2_s6, v1p5_s7, v1p2_s7;

	// stage 6: square times p6 and p3, split at bit 32
	logic signed [48:0] sp6lo_f, sp3lo_f;
	logic signed [47:0] sp6hi_f, sp3hi_f;
	assign sp6lo_f = $signed({1'b0, sq_s5[31:0]}) * p6;
	assign sp3lo_f = $signed({1'b0, sq_s5[31:0]}) * p3;
	assign sp6hi_f = $signed(sq_s5[63:32]) * p6;
	assign sp3hi_f = $signed(sq_s5[63:32]) * p3;
	logic [48:0] sp6lo_s6, sp3lo_s6;
	logic [31:0] sp6hi_s6, sp3hi_s6;

	// stage 7
	logic [63:0] sqp6_s7, sqp3_s7;

	// stage 8: divisor operand and v2
	logic [63:0] v2_c, vb_c, sqp3sh_c;
	assign sqp3sh_c = $signed(sqp3_s7) >>> 8;
	assign v2_c = sqp6_s7 + {v1p5_s7[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
	assign vb_c = sqp3sh_c + {{3{v1p2_s7[48]}}, v1p2_s7, 12'b0} + VB_BIAS;
	logic [63:0] v2_s8, vb_s8;

	// stage 9: divisor product, numerator difference
	logic [20:0] pnum_c;
	logic [47:0] vbhi_f;
	assign pnum_c = P_BASE - {1'b0, adcp_s8};
	assign vbhi_f = vb_s8[63:32] * p1;
	logic [47:0] vblo_s9;
	logic [31:0] vbhi_s9;
	logic [63:0] diff_s9;

	// stage 10: divisor, numerator scale partials
	logic [63:0] dsum_c;
	logic [43:0] nhi_f;
	assign dsum_c = {16'b0, vblo_s9} + {vbhi_s9, 32'b0};
	assign nhi_f  = diff_s9[63:32] * PRESS_SCALE;
	logic [30:0] den_s10, den_s11;
	logic [43:0] nlo_s10;
	logic [31:0] nhi_s10;

	// stage 11
	logic [63:0] num_s11;

	// stage 12: magnitudes and signs
	div_in_t din_s12;

	// stage 13: signed quotient
	logic [63:0] p_s13, p_s14, p_s15, p_s16;
	logic        dz_s13, dz_s14, dz_s15, dz_s16, dz_s17;
	logic [15:0] tc_s13, tc_s14, tc_s15, tc_s16, tc_s17;
	logic [31:0] tf_s13, tf_s14, tf_s15, tf_s16, tf_s17;

	// stage 14: q squared and p times p8
	logic [63:0]        q_c;
	logic [63:0]        qq_f, qx_f;
	logic signed [48:0] p8lo_f;
	logic signed [47:0] p8hi_f;
	assign q_c    = $signed(p_s13) >>> 13;
	assign qq_f   = q_c[31:0] * q_c[31:0];
	assign qx_f   = q_c[31:0] * q_c[63:32];
	assign p8lo_f = $signed({1'b0, p_s13[31:0]}) * p8;
	assign p8hi_f = $signed(p_s13[63:32]) * p8;
	logic [63:0] qq_s14;
	logic [31:0] qx_s14, p8hi_s14;
	logic [48:0] p8lo_s14;

	// stage 15
	logic [63:0] w2sum_c;
	assign w2sum_c = {{15{p8lo_s14[48]}}, p8lo_s14} + {p8hi_s14, 32'b0};
	logic [63:0] s_s15, w2_s15, w2_s16;

	// stage 16: q squared times p9
	logic signed [48:0] slo_f;
	logic signed [47:0] shi_f;
	assign slo_f = $signed({1'b0, s_s15[31:0]}) * p9;
	assign shi_f = $signed(s_s15[63:32]) * p9;
	logic [48:0] slo_s16;
	logic [31:0] shi_s16;

	// stage 17: sum of terms
	logic [63:0] w1sum_c, w1_c;
	assign w1sum_c = {{15{slo_s16[48]}}, slo_s16} + {shi_s16, 32'b0};
	assign w1_c    = $signed(w1sum_c) >>> 25;
	logic [63:0] tot_s17;

	// final scaling and saturation
	logic [63:0] r_c, totsh_c;
	res_t        res_c;
	assign totsh_c = $signed(tot_s17) >>> 8;
	assign r_c = totsh_c + {{44{p7[15]}}, p7, 4'b0};
	always_comb begin
		res_c.tc = tc_s17;
		res_c.tf = tf_s17;
		res_c.dz = dz_s17;
		if (dz_s17 || r_c[63]) begin
			res_c.press = '0;
		end else if (|r_c[62:32]) begin
			res_c.press = '1;
		end else begin
			res_c.press = r_c[31:0];
		end
	end

	bic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (din_s12),
		.dout   (dout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0; v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;  v_s3  <= v_s2;  v_s4  <= v_s3;  v_s5  <= v_s4;
			v_s6  <= v_s5;  v_s7  <= v_s6;  v_s8  <= v_s7;  v_s9  <= v_s8;
			v_s10 <= v_s9;  v_s11 <= v_s10;
			v_s13 <= dout.valid;
			v_s14 <= v_s13; v_s15 <= v_s14; v_s16 <= v_s15; v_s17 <= v_s16;
		end
	end

	// divider operands carry the stage valid, so they clear with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_s12 <= '0;
		end else if (en) begin
			din_s12.valid <= v_s11;
			din_s12.num   <= num_s11[63] ? (64'd0 - num_s11) : num_s11;
			din_s12.den   <= den_s11[30] ? (31'd0 - den_s11) : den_s11;
			din_s12.neg   <= num_s11[63] ^ den_s11[30];
			din_s12.dz    <= (den_s11 == '0);
			din_s12.tc    <= tc_s11;
			din_s12.tf    <= tf_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_s1   <= at_f[31:0];
			dd_s1   <= dd_f[31:0];
			adcp_s1 <= raw_pressure;

			tv1_s2  <= $signed(at_s1) >>> 11;
			xt3_s2  <= xt3_f[31:0];
			adcp_s2 <= adcp_s1;

			tf_s3   <= $signed(tv1_s2) + ($signed(xt3_s2) >>> 14);
			adcp_s3 <= adcp_s2;

			v1_s4   <= $signed({tf_s3[31], tf_s3}) - T_OFFSET;
			tc_s4   <= tc_sat;
			tf_s4   <= tf_s3;
			adcp_s4 <= adcp_s3;

			sq_s5   <= sq_f[63:0];
			v1p5_s5 <= v1p5_f;
			v1p2_s5 <= v1p2_f;
			tc_s5   <= tc_s4;
			tf_s5   <= tf_s4;
			adcp_s5 <= adcp_s4;

			sp6lo_s6 <= sp6lo_f;
			sp3lo_s6 <= sp3lo_f;
			sp6hi_s6 <= sp6hi_f[31:0];
			sp3hi_s6 <= sp3hi_f[31:0];
			v1p5_s6  <= v1p5_s5;
			v1p2_s6  <= v1p2_s5;
			tc_s6    <= tc_s5;
			tf_s6    <= tf_s5;
			adcp_s6  <= adcp_s5;

			sqp6_s7 <= {{15{sp6lo_s6[48]}}, sp6lo_s6} + {sp6hi_s6, 32'b0};
			sqp3_s7 <= {{15{sp3lo_s6[48]}}, sp3lo_s6} + {sp3hi_s6, 32'b0};
			v1p5_s7 <= v1p5_s6;
			v1p2_s7 <= v1p2_s6;
			tc_s7   <= tc_s6;
			tf_s7   <= tf_s6;
			adcp_s7 <= adcp_s6;

			v2_s8   <= v2_c;
			vb_s8   <= vb_c;
			tc_s8   <= tc_s7;
			tf_s8   <= tf_s7;
			adcp_s8 <= adcp_s7;

			vblo_s9 <= vb_s8[31:0] * p1;
			vbhi_s9 <= vbhi_f[31:0];
			diff_s9 <= {12'b0, pnum_c, 31'b0} - v2_s8;
			tc_s9   <= tc_s8;
			tf_s9   <= tf_s8;

			den_s10 <= dsum_c[63:33];
			nlo_s10 <= diff_s9[31:0] * PRESS_SCALE;
			nhi_s10 <= nhi_f[31:0];
			tc_s10  <= tc_s9;
			tf_s10  <= tf_s9;

			num_s11 <= {20'b0, nlo_s10} + {nhi_s10, 32'b0};
			den_s11 <= den_s10;
			tc_s11  <= tc_s10;
			tf_s11  <= tf_s10;

			p_s13  <= dout.neg ? (64'd0 - dout.quot) : dout.quot;
			dz_s13 <= dout.dz;
			tc_s13 <= dout.tc;
			tf_s13 <= dout.tf;

			qq_s14   <= qq_f;
			qx_s14   <= qx_f[31:0];
			p8lo_s14 <= p8lo_f;
			p8hi_s14 <= p8hi_f[31:0];
			p_s14    <= p_s13;
			dz_s14   <= dz_s13;
			tc_s14   <= tc_s13;
			tf_s14   <= tf_s13;

			// ql*qh lands at bit 33, i.e. 2*ql*qh at bit 32
			s_s15  <= qq_s14 + {qx_s14[30:0], 33'b0};
			w2_s15 <= $signed(w2sum_c) >>> 19;
			p_s15  <= p_s14;
			dz_s15 <= dz_s14;
			tc_s15 <= tc_s14;
			tf_s15 <= tf_s14;

			slo_s16 <= slo_f;
			shi_s16 <= shi_f[31:0];
			w2_s16  <= w2_s15;
			p_s16   <= p_s15;
			dz_s16  <= dz_s15;
			tc_s16  <= tc_s15;
			tf_s16  <= tf_s15;

			tot_s17 <= p_s16 + w1_c + w2_s16;
			dz_s17  <= dz_s16;
			tc_s17  <= tc_s16;
			tf_s17  <= tf_s16;
		end
	end

	// two-entry output buffer: head drives the port, skid catches one more transfer
	logic push, pop;
	res_t head_q, skid_q;
	assign push = en && v_s17;
	assign pop  = (cnt_q != 2'd0) && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			head_q <= skid_q;
		end else if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= res_c;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			skid_q <= res_c;
		end
	end

	assign out_valid         = (cnt_q != 2'd0);
	assign temperature_centi = $signed(head_q.tc);
	assign fine_temperature  = $signed(head_q.tf);
	assign pressure_q24_8    = head_q.press;
	assign divide_by_zero    = head_q.dz;

	`BIC_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "output buffer count out of range")
	`BIC_ASSERT_NOW(a_dz_zero, clk, arst_n, out_valid && divide_by_zero, pressure_q24_8 == '0, "dz pressure")
	`BIC_ASSERT_NEXT(a_full_hold, clk, arst_n, in_stall, $stable(v_s17) && $stable(v_s1), "moved while full")

endmodule
